[rtl/ill_pkg.sv]
// ----------------------------------------------------------------------------
// ill_pkg: shared types and constants of the interpolated lookup table
// Field widths, command codes and the queue entry passed from front to back.
// ----------------------------------------------------------------------------
package ill_pkg;

  localparam int VALUE_W    = 20;  // signed Q3.16 lookup input
  localparam int INDEX_W    = 10;  // entry index of a write item
  localparam int ENTRY_W    = 24;  // unsigned Q16.8 table sample
  localparam int FRAC_W     = 16;  // fraction of the scaled position
  localparam int RESULT_W   = 16;  // rounded, saturated result
  localparam int NCFG_W     = 11;  // entries_in_use register
  localparam int POS_W      = 32;  // scaled position, signed, 16 fraction bits
  localparam int ADDR_MAX_W = 16;  // widest table address for any depth
  localparam int IN_DATA_W  = 56;  // packed input fields, padded to bytes
  localparam int OUT_DATA_W = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_INTERP,
    OP_ENDPOINT
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [ADDR_MAX_W-1:0] addr;
    logic [FRAC_W-1:0]     frac;
    logic [ENTRY_W-1:0]    data;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

endpackage

[rtl/interpolated_lut_lookup.sv]
// ----------------------------------------------------------------------------
// interpolated_lut_lookup: linear interpolated curve table
// Stores curve samples and returns rounded, interpolated lookups.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata / data                         | tuser
//  --------+-----------+--------------------------------------+-----------
//  in_     | slave     | lookup_value, entry_index, entry_data| cmd
//  out_    | master    | looked_up                            | -
//  cfg_    | slave     | entries_in_use                       | -
//
//  One item per clock sustained while the output is not stalled, lookups and
//  writes alike. A lookup's result passes, in order: the front register
//  takes the item, then queue slot, table read, interpolation multiply, round
//  and output register.
//  The table has one write port and two read ports; a write item takes the
//  same slot as a lookup and lands before any later lookup reads.
//  Reset clears control state only; table contents are undefined until written.
//  A stalled output holds the back pipeline; the four-entry queue and the
//  front register keep taking items until the queue fills.
//
module interpolated_lut_lookup #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: [19:0] lookup_value, [29:20] entry_index, [53:30] entry_data,
  //           [55:54] zero
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ill_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: [0] cmd (0 lookup, 1 write)
  input  logic                           in_tuser,
  // out_tdata: [15:0] looked_up
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ill_pkg::OUT_DATA_W-1:0] out_tdata,
  // cfg_data: [10:0] entries_in_use
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ill_pkg::NCFG_W-1:0]     cfg_data
);
  import ill_pkg::*;

  // Keep entries_in_use as (clamped count - 1): that is the scale factor
  // and the last valid index.
  localparam logic [NCFG_W-1:0] NM1_MAX   = NCFG_W'(TABLE_DEPTH - 1);
  localparam logic [NCFG_W-1:0] NM1_RESET =
    NCFG_W'((TABLE_DEPTH < 1024) ? TABLE_DEPTH - 1 : 1023);

  logic [NCFG_W-1:0] nm1_r;
  logic [NCFG_W-1:0] nm1_nxt;
  push_t             push;
  logic              q_ready;
  logic              q_pop;
  logic              q_head_valid;
  entry_t            q_head;

  assign cfg_ready = 1'b1;

  // Clamp the count to [2, TABLE_DEPTH] on the way in.
  always_comb begin
    if (cfg_data < NCFG_W'(2)) begin
      nm1_nxt = NCFG_W'(1);
    end else if (32'(cfg_data) > 32'(TABLE_DEPTH)) begin
      nm1_nxt = NM1_MAX;
    end else begin
      nm1_nxt = cfg_data - NCFG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm1_r <= NM1_RESET;
    end else if (cfg_valid && cfg_ready) begin
      nm1_r <= nm1_nxt;
    end
  end

  // Front: accept, scale by count - 1, classify into write/interp/endpoint.
  ill_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .nm1       (nm1_r),
    .q_ready   (q_ready),
    .push      (push)
  );

  // Decouple front from back.
  ill_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Back: table access, interpolate, round half up, saturate.
  ill_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_nm1_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nm1_r >= NCFG_W'(1)) && (32'(nm1_r) <= 32'(TABLE_DEPTH - 1)))
    else $error("entry count register outside the table");

endmodule

[rtl/ill_front.sv]
// ----------------------------------------------------------------------------
// ill_front: input stage of the interpolated lookup table
// Accepts items, scales lookups by the entry count and classifies them.
// ----------------------------------------------------------------------------
module ill_front #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ill_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  input  logic [ill_pkg::NCFG_W-1:0]    nm1,
  input  logic                          q_ready,
  output ill_pkg::push_t                push
);
  import ill_pkg::*;

  logic                      f_valid_r;
  logic                      f_cmd_r;
  logic signed [POS_W-1:0]   f_pos_r;
  logic signed [POS_W-1:0]   f_pos_nxt;
  logic [INDEX_W-1:0]        f_index_r;
  logic [ENTRY_W-1:0]        f_data_r;
  logic signed [VALUE_W-1:0] in_value;
  logic                      advance;
  logic [POS_W-17:0]         pos_idx;
  logic                      pos_neg;
  logic                      pos_high;
  logic                      write_keep;
  entry_t                    entry;

  assign in_value  = $signed(in_tdata[VALUE_W-1:0]);
  assign advance   = !f_valid_r || q_ready;
  assign in_tready = advance;
  assign f_pos_nxt = POS_W'(in_value) * POS_W'($signed({1'b0, nm1}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (advance) begin
      f_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_tvalid) begin
      f_cmd_r   <= in_tuser;
      f_pos_r   <= f_pos_nxt;
      f_index_r <= in_tdata[VALUE_W +: INDEX_W];
      f_data_r  <= in_tdata[VALUE_W+INDEX_W +: ENTRY_W];
    end
  end

  // The sign bit rides along in pos_idx; negative positions take the
  // first-entry branch before pos_idx is looked at.
  assign pos_neg    = f_pos_r[POS_W-1];
  assign pos_idx    = f_pos_r[POS_W-1:FRAC_W];
  assign pos_high   = (POS_W-17)'(nm1) <= pos_idx;
  assign write_keep = 32'(f_index_r) < 32'(TABLE_DEPTH);

  always_comb begin
    entry.op   = OP_INTERP;
    entry.addr = ADDR_MAX_W'(pos_idx);
    entry.frac = f_pos_r[FRAC_W-1:0];
    entry.data = f_data_r;
    if (f_cmd_r == CMD_WRITE) begin
      entry.op   = OP_WRITE;
      entry.addr = ADDR_MAX_W'(f_index_r);
      entry.frac = '0;
    end else if (pos_neg) begin
      entry.op   = OP_ENDPOINT;
      entry.addr = '0;
      entry.frac = '0;
    end else if (pos_high) begin
      entry.op   = OP_ENDPOINT;
      entry.addr = ADDR_MAX_W'(nm1);
      entry.frac = '0;
    end
  end

  // Drop writes beyond the table here; they never reach the queue.
  assign push.valid = f_valid_r && q_ready && ((f_cmd_r == CMD_LOOKUP) || write_keep);
  assign push.entry = entry;

  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid_r && !q_ready |=> f_valid_r && $stable(f_pos_r))
    else $error("front stage lost an item while the queue was full");

endmodule

[rtl/ill_queue.sv]
// ----------------------------------------------------------------------------
// ill_queue: short queue between front and back
// Holds classified items so either side can stall on its own.
// ----------------------------------------------------------------------------
module ill_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  ill_pkg::push_t  push,
  output logic            ready,
  input  logic            pop,
  output logic            head_valid,
  output ill_pkg::entry_t head
);
  import ill_pkg::*;

  entry_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_push;
  logic                do_pop;

  assign ready      = count_r != QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push.valid && ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> ready)
    else $error("push offered to a full queue");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) || (count_r == QCNT_W'(QUEUE_DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule

[rtl/ill_back.sv]
// ----------------------------------------------------------------------------
// ill_back: table memory and interpolation pipeline
// Writes entries, reads neighbor pairs, interpolates, rounds and saturates.
// ----------------------------------------------------------------------------
module ill_back #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           head_valid,
  input  ill_pkg::entry_t                head,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ill_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ill_pkg::*;

  localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PW = 42;
  localparam logic signed [PW-1:0] HALF_LSB = PW'(64'sd8388608);

  logic [ENTRY_W-1:0]         curve_mem [TABLE_DEPTH];
  logic                       adv;
  logic [AW-1:0]              ra;
  logic [AW-1:0]              rb;
  logic                       s1_valid_r;
  logic [FRAC_W-1:0]          s1_frac_r;
  logic [ENTRY_W-1:0]         s1_ea_r;
  logic [ENTRY_W-1:0]         s1_eb_r;
  logic signed [ENTRY_W:0]    diff;
  logic signed [PW-1:0]       s2_prod_nxt;
  logic signed [PW-1:0]       s2_prod_r;
  logic [ENTRY_W-1:0]         s2_base_r;
  logic                       s2_valid_r;
  logic signed [PW-1:0]       acc;
  logic signed [PW-1:0]       rnd;
  logic [RESULT_W:0]          r_wide;
  logic [RESULT_W-1:0]        out_data_nxt;
  logic                       out_valid_r;
  logic [RESULT_W-1:0]        out_data_r;

  // Whole back pipeline advances together; hold it while the result waits.
  assign adv = !out_valid_r || out_tready;
  assign pop = adv && head_valid;
  assign ra  = AW'(head.addr);
  assign rb  = (head.op == OP_INTERP) ? ra + AW'(1) : ra;

  always_ff @(posedge clk) begin
    if (pop && (head.op == OP_WRITE)) begin
      curve_mem[ra] <= head.data;
    end
    if (adv) begin
      s1_ea_r <= curve_mem[ra];
      s1_eb_r <= curve_mem[rb];
    end
  end

  assign diff        = $signed({1'b0, s1_eb_r}) - $signed({1'b0, s1_ea_r});
  assign s2_prod_nxt = PW'($signed({1'b0, s1_frac_r})) * PW'(diff);

  assign acc    = $signed(PW'({s2_base_r, 16'b0})) + s2_prod_r;
  assign rnd    = acc + HALF_LSB;
  assign r_wide = rnd[24 +: RESULT_W+1];

  always_comb begin
    if (acc[PW-1]) begin
      out_data_nxt = '0;
    end else if (r_wide[RESULT_W]) begin
      out_data_nxt = '1;
    end else begin
      out_data_nxt = r_wide[RESULT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= pop && (head.op != OP_WRITE);
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_frac_r  <= head.frac;
      s2_prod_r  <= s2_prod_nxt;
      s2_base_r  <= s1_ea_r;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (head.op == OP_WRITE) |=> !s1_valid_r)
    else $error("write item started a result");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s1_valid_r) && $stable(s2_valid_r))
    else $error("back pipeline moved during a stall");

endmodule
